/* hw/rtl/rbu_pkg.sv */
// rbu_pkg: shared widths, factor and equation codes and the blend setup
// struct for the rgba blend unit. No dependencies.
package rbu_pkg;

  localparam int CHAN_W = 8;
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

  localparam int FACTOR_W = 4;
  localparam int EQ_W = 3;

  localparam logic [FACTOR_W-1:0] FACTOR_ZERO          = 4'd0;
  localparam logic [FACTOR_W-1:0] FACTOR_ONE           = 4'd1;
  localparam logic [FACTOR_W-1:0] FACTOR_SRC_COL       = 4'd2;
  localparam logic [FACTOR_W-1:0] FACTOR_INV_SRC_COL   = 4'd3;
  localparam logic [FACTOR_W-1:0] FACTOR_DST_COL       = 4'd4;
  localparam logic [FACTOR_W-1:0] FACTOR_INV_DST_COL   = 4'd5;
  localparam logic [FACTOR_W-1:0] FACTOR_SRC_ALPHA     = 4'd6;
  localparam logic [FACTOR_W-1:0] FACTOR_INV_SRC_ALPHA = 4'd7;
  localparam logic [FACTOR_W-1:0] FACTOR_DST_ALPHA     = 4'd8;
  localparam logic [FACTOR_W-1:0] FACTOR_INV_DST_ALPHA = 4'd9;
  localparam logic [FACTOR_W-1:0] FACTOR_ALPHA_SAT     = 4'd10;
  localparam logic [FACTOR_W-1:0] FACTOR_CONST_COL     = 4'd11;
  localparam logic [FACTOR_W-1:0] FACTOR_INV_CONST_COL = 4'd12;
  localparam logic [FACTOR_W-1:0] FACTOR_CONST_ALPHA   = 4'd13;
  localparam logic [FACTOR_W-1:0] FACTOR_INV_CONST_ALPHA = 4'd14;

  localparam logic [EQ_W-1:0] EQ_ADD     = 3'd0;
  localparam logic [EQ_W-1:0] EQ_SUB     = 3'd1;
  localparam logic [EQ_W-1:0] EQ_REV_SUB = 3'd2;
  localparam logic [EQ_W-1:0] EQ_MIN     = 3'd3;
  localparam logic [EQ_W-1:0] EQ_MAX     = 3'd4;

  typedef struct packed {
    logic [FACTOR_W-1:0] source_factor;
    logic [FACTOR_W-1:0] dest_factor;
    logic [EQ_W-1:0]     equation;
  } blend_cfg_t;

endpackage

/* hw/rtl/rbu_channel.sv */
// rbu_channel: blends one color channel: factor select, scale by f/255,
// combine by the equation and saturate. Depends on rbu_pkg.
module rbu_channel (
  input  rbu_pkg::blend_cfg_t                cfg,
  input  logic                               alpha_mode,
  input  logic [rbu_pkg::CHAN_W-1:0]         s,
  input  logic [rbu_pkg::CHAN_W-1:0]         d,
  input  logic [rbu_pkg::CHAN_W-1:0]         sa,
  input  logic [rbu_pkg::CHAN_W-1:0]         da,
  input  logic [rbu_pkg::CHAN_W-1:0]         cc,
  input  logic [rbu_pkg::CHAN_W-1:0]         ca,
  output logic [rbu_pkg::CHAN_W-1:0]         res
);
  import rbu_pkg::*;

  function automatic logic [CHAN_W-1:0] pick(
    input logic [FACTOR_W-1:0] code,
    input logic [CHAN_W-1:0]   cs,
    input logic [CHAN_W-1:0]   cd,
    input logic [CHAN_W-1:0]   as,
    input logic [CHAN_W-1:0]   ad,
    input logic [CHAN_W-1:0]   kc,
    input logic [CHAN_W-1:0]   ka,
    input logic                is_alpha
  );
    logic [CHAN_W-1:0] inv_ad;
    logic [CHAN_W-1:0] f;
    inv_ad = CHAN_MAX - ad;
    unique case (code)
      FACTOR_ONE:             f = CHAN_MAX;
      FACTOR_SRC_COL:         f = cs;
      FACTOR_INV_SRC_COL:     f = CHAN_MAX - cs;
      FACTOR_DST_COL:         f = cd;
      FACTOR_INV_DST_COL:     f = CHAN_MAX - cd;
      FACTOR_SRC_ALPHA:       f = as;
      FACTOR_INV_SRC_ALPHA:   f = CHAN_MAX - as;
      FACTOR_DST_ALPHA:       f = ad;
      FACTOR_INV_DST_ALPHA:   f = inv_ad;
      FACTOR_ALPHA_SAT:       f = is_alpha ? CHAN_MAX : ((as < inv_ad) ? as : inv_ad);
      FACTOR_CONST_COL:       f = kc;
      FACTOR_INV_CONST_COL:   f = CHAN_MAX - kc;
      FACTOR_CONST_ALPHA:     f = ka;
      FACTOR_INV_CONST_ALPHA: f = CHAN_MAX - ka;
      default:                f = '0;
    endcase
    return f;
  endfunction

  logic [CHAN_W-1:0]   fs, fd;
  logic [2*CHAN_W-1:0] ps, pd;
  logic [2*CHAN_W-1:0] qs, qd;
  logic [CHAN_W-1:0]   ts, td;
  logic [CHAN_W:0]     sum;

  assign fs = pick(cfg.source_factor, s, d, sa, da, cc, ca, alpha_mode);
  assign fd = pick(cfg.dest_factor, s, d, sa, da, cc, ca, alpha_mode);

  assign ps = (2*CHAN_W)'(s) * (2*CHAN_W)'(fs);
  assign pd = (2*CHAN_W)'(d) * (2*CHAN_W)'(fd);

  // exact floor(p / 255) for p up to 255*255
  assign qs = ps + (2*CHAN_W)'(1) + (2*CHAN_W)'(ps[2*CHAN_W-1:CHAN_W]);
  assign qd = pd + (2*CHAN_W)'(1) + (2*CHAN_W)'(pd[2*CHAN_W-1:CHAN_W]);
  assign ts = qs[2*CHAN_W-1:CHAN_W];
  assign td = qd[2*CHAN_W-1:CHAN_W];

  assign sum = {1'b0, ts} + {1'b0, td};

  always_comb begin
    unique case (cfg.equation)
      EQ_SUB:     res = (ts < td) ? '0 : ts - td;
      EQ_REV_SUB: res = (td < ts) ? '0 : td - ts;
      EQ_MIN:     res = (ts < td) ? ts : td;
      EQ_MAX:     res = (ts > td) ? ts : td;
      default:    res = sum[CHAN_W] ? CHAN_MAX : sum[CHAN_W-1:0];
    endcase
  end

endmodule

/* hw/rtl/rgba_blend_unit.sv */
// Blend unit: registers the incoming pixel pair, setup registers and the
// result beat. Depends on rbu_pkg and rbu_channel.
// rgba_blend_unit takes one beat per clock while pix_stall is low: a source and a destination
// RGBA8888 pixel, and returns one blended pixel per beat once it has passed
// the input register, then the result register. Each channel is scaled by
// its source and destination factor (x*f/255, truncated), combined by add,
// subtract, reverse subtract, min or max, and saturated to 0..255; alpha uses
// the same setup with alpha values in place of color. Sustained rate is one
// pixel per clock: all blend math is one combinational pass between the two
// registers, and each register refills on the clock it is emptied; a stalled
// result holds both stages. Setup registers (index 0..6: source factor, dest
// factor, equation, constant red, green, blue, alpha) are written through
// cfg_write and should only change while no beat is in flight.
module rgba_blend_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [2:0]                 cfg_index,
  input  logic [rbu_pkg::CHAN_W-1:0] cfg_data,
  input  logic                       pix_valid,
  output logic                       pix_stall,
  input  logic [rbu_pkg::CHAN_W-1:0] src_red,
  input  logic [rbu_pkg::CHAN_W-1:0] src_green,
  input  logic [rbu_pkg::CHAN_W-1:0] src_blue,
  input  logic [rbu_pkg::CHAN_W-1:0] src_alpha,
  input  logic [rbu_pkg::CHAN_W-1:0] dst_red,
  input  logic [rbu_pkg::CHAN_W-1:0] dst_green,
  input  logic [rbu_pkg::CHAN_W-1:0] dst_blue,
  input  logic [rbu_pkg::CHAN_W-1:0] dst_alpha,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rbu_pkg::CHAN_W-1:0] out_red,
  output logic [rbu_pkg::CHAN_W-1:0] out_green,
  output logic [rbu_pkg::CHAN_W-1:0] out_blue,
  output logic [rbu_pkg::CHAN_W-1:0] out_alpha
);
  import rbu_pkg::*;

  localparam logic [2:0] REG_SOURCE_FACTOR = 3'd0;
  localparam logic [2:0] REG_DEST_FACTOR   = 3'd1;
  localparam logic [2:0] REG_EQUATION      = 3'd2;
  localparam logic [2:0] REG_CONST_RED     = 3'd3;
  localparam logic [2:0] REG_CONST_GREEN   = 3'd4;
  localparam logic [2:0] REG_CONST_BLUE    = 3'd5;
  localparam logic [2:0] REG_CONST_ALPHA   = 3'd6;

  blend_cfg_t        cfg;
  logic [CHAN_W-1:0] const_red, const_green, const_blue, const_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_factor <= FACTOR_ONE;
      cfg.dest_factor   <= FACTOR_ZERO;
      cfg.equation      <= EQ_ADD;
      const_red         <= '0;
      const_green       <= '0;
      const_blue        <= '0;
      const_alpha       <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SOURCE_FACTOR: cfg.source_factor <= cfg_data[FACTOR_W-1:0];
        REG_DEST_FACTOR:   cfg.dest_factor   <= cfg_data[FACTOR_W-1:0];
        REG_EQUATION:      cfg.equation      <= cfg_data[EQ_W-1:0];
        REG_CONST_RED:     const_red         <= cfg_data;
        REG_CONST_GREEN:   const_green       <= cfg_data;
        REG_CONST_BLUE:    const_blue        <= cfg_data;
        REG_CONST_ALPHA:   const_alpha       <= cfg_data;
        default: ;
      endcase
    end
  end

  // two-stage pipeline: input register, then result register
  logic              in_full;
  logic              out_ready, in_ready;
  logic [CHAN_W-1:0] sr, sg, sb, sa, dr, dg, db, da;
  logic [CHAN_W-1:0] res_red, res_green, res_blue, res_alpha;

  assign out_ready = !out_valid || !out_stall;
  assign in_ready  = !in_full || out_ready;
  assign pix_stall = !in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_valid && in_ready) begin
      sr <= src_red;
      sg <= src_green;
      sb <= src_blue;
      sa <= src_alpha;
      dr <= dst_red;
      dg <= dst_green;
      db <= dst_blue;
      da <= dst_alpha;
    end
  end

  rbu_channel u_red (
    .cfg(cfg), .alpha_mode(1'b0), .s(sr), .d(dr), .sa(sa), .da(da),
    .cc(const_red), .ca(const_alpha), .res(res_red)
  );

  rbu_channel u_green (
    .cfg(cfg), .alpha_mode(1'b0), .s(sg), .d(dg), .sa(sa), .da(da),
    .cc(const_green), .ca(const_alpha), .res(res_green)
  );

  rbu_channel u_blue (
    .cfg(cfg), .alpha_mode(1'b0), .s(sb), .d(db), .sa(sa), .da(da),
    .cc(const_blue), .ca(const_alpha), .res(res_blue)
  );

  rbu_channel u_alpha (
    .cfg(cfg), .alpha_mode(1'b1), .s(sa), .d(da), .sa(sa), .da(da),
    .cc(const_alpha), .ca(const_alpha), .res(res_alpha)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && in_full) begin
      out_red   <= res_red;
      out_green <= res_green;
      out_blue  <= res_blue;
      out_alpha <= res_alpha;
    end
  end

endmodule

/* bench/tb_rgba_blend_unit.sv */
// tb_rgba_blend_unit: self-checking bench for the rgba blend unit, driving
// pixel pairs and setup writes and scoring every blended beat in order
// against its own blend predictor. Depends on rbu_pkg and rgba_blend_unit.
module tb_rgba_blend_unit;
  import rbu_pkg::*;

  localparam logic [2:0] REG_SRC_FACTOR  = 3'd0;
  localparam logic [2:0] REG_DST_FACTOR  = 3'd1;
  localparam logic [2:0] REG_EQUATION    = 3'd2;
  localparam logic [2:0] REG_CONST_RED   = 3'd3;
  localparam logic [2:0] REG_CONST_GREEN = 3'd4;
  localparam logic [2:0] REG_CONST_BLUE  = 3'd5;
  localparam logic [2:0] REG_CONST_ALPHA = 3'd6;
  localparam logic [2:0] REG_UNUSED      = 3'd7;

  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int PHASE_BEATS = 40;
  localparam int RANDOM_PHASES = 10;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } rgba_t;

  typedef enum logic [1:0] {RX_READY, RX_RANDOM, RX_BURSTY} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CHAN_W-1:0] cfg_data = '0;
  logic pix_valid = 1'b0;
  logic pix_stall;
  rgba_t src_pix = '0;
  rgba_t dst_pix = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CHAN_W-1:0] out_red, out_green, out_blue, out_alpha;

  // predictor copy of the setup registers
  logic [FACTOR_W-1:0] cur_src_factor = FACTOR_ONE;
  logic [FACTOR_W-1:0] cur_dst_factor = FACTOR_ZERO;
  logic [EQ_W-1:0] cur_equation = EQ_ADD;
  logic [CHAN_W-1:0] cur_const_red = '0;
  logic [CHAN_W-1:0] cur_const_green = '0;
  logic [CHAN_W-1:0] cur_const_blue = '0;
  logic [CHAN_W-1:0] cur_const_alpha = '0;

  rgba_t blended_q[$];
  int errors = 0;
  rx_mode_t rx_mode = RX_READY;
  int hold_seq = 0;

  rgba_blend_unit uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .src_red(src_pix.red),
    .src_green(src_pix.green),
    .src_blue(src_pix.blue),
    .src_alpha(src_pix.alpha),
    .dst_red(dst_pix.red),
    .dst_green(dst_pix.green),
    .dst_blue(dst_pix.blue),
    .dst_alpha(dst_pix.alpha),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue),
    .out_alpha(out_alpha)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [CHAN_W-1:0] blend_weight(
    logic [FACTOR_W-1:0] code, logic [CHAN_W-1:0] cs, logic [CHAN_W-1:0] cd,
    logic [CHAN_W-1:0] sa, logic [CHAN_W-1:0] da, logic [CHAN_W-1:0] cc,
    logic [CHAN_W-1:0] ac, bit alpha_ch);
    logic [CHAN_W-1:0] inv_da;
    inv_da = CHAN_MAX - da;
    case (code)
      FACTOR_ONE:             return CHAN_MAX;
      FACTOR_SRC_COL:         return cs;
      FACTOR_INV_SRC_COL:     return CHAN_MAX - cs;
      FACTOR_DST_COL:         return cd;
      FACTOR_INV_DST_COL:     return CHAN_MAX - cd;
      FACTOR_SRC_ALPHA:       return sa;
      FACTOR_INV_SRC_ALPHA:   return CHAN_MAX - sa;
      FACTOR_DST_ALPHA:       return da;
      FACTOR_INV_DST_ALPHA:   return inv_da;
      // alpha saturate acts as one on the alpha channel
      FACTOR_ALPHA_SAT:       return alpha_ch ? CHAN_MAX : ((sa < inv_da) ? sa : inv_da);
      FACTOR_CONST_COL:       return cc;
      FACTOR_INV_CONST_COL:   return CHAN_MAX - cc;
      FACTOR_CONST_ALPHA:     return ac;
      FACTOR_INV_CONST_ALPHA: return CHAN_MAX - ac;
      default:                return '0;
    endcase
  endfunction

  function automatic logic [CHAN_W-1:0] mix_channel(
    logic [CHAN_W-1:0] s, logic [CHAN_W-1:0] d, logic [CHAN_W-1:0] sa,
    logic [CHAN_W-1:0] da, logic [CHAN_W-1:0] cc, bit alpha_ch);
    int fs, fd, ts, td, r;
    fs = blend_weight(cur_src_factor, s, d, sa, da, cc, cur_const_alpha, alpha_ch);
    fd = blend_weight(cur_dst_factor, s, d, sa, da, cc, cur_const_alpha, alpha_ch);
    ts = (int'(s) * fs) / int'(CHAN_MAX);
    td = (int'(d) * fd) / int'(CHAN_MAX);
    case (cur_equation)
      EQ_SUB:     r = ts - td;
      EQ_REV_SUB: r = td - ts;
      EQ_MIN:     r = (ts < td) ? ts : td;
      EQ_MAX:     r = (ts > td) ? ts : td;
      default:    r = ts + td;
    endcase
    if (r < 0) r = 0;
    if (r > int'(CHAN_MAX)) r = int'(CHAN_MAX);
    return r[CHAN_W-1:0];
  endfunction

  function automatic rgba_t blend_pixel(rgba_t s, rgba_t d);
    rgba_t res;
    res.red   = mix_channel(s.red, d.red, s.alpha, d.alpha, cur_const_red, 1'b0);
    res.green = mix_channel(s.green, d.green, s.alpha, d.alpha, cur_const_green, 1'b0);
    res.blue  = mix_channel(s.blue, d.blue, s.alpha, d.alpha, cur_const_blue, 1'b0);
    res.alpha = mix_channel(s.alpha, d.alpha, s.alpha, d.alpha, cur_const_alpha, 1'b1);
    return res;
  endfunction

  function automatic logic [CHAN_W-1:0] rand_channel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CHAN_MAX;
      default: return CHAN_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic rgba_t rand_pixel();
    rgba_t p;
    p.red = rand_channel();
    p.green = rand_channel();
    p.blue = rand_channel();
    p.alpha = rand_channel();
    return p;
  endfunction

  // every accepted input beat gets its blended pixel queued
  always @(posedge clk) begin
    if (!rst && pix_valid && !pix_stall)
      blended_q.push_back(blend_pixel(src_pix, dst_pix));
  end

  always @(posedge clk) begin
    rgba_t want;
    if (!rst && out_valid && !out_stall) begin
      if (blended_q.size() == 0) begin
        errors++;
        $display("%0t unexpected beat: got %02h %02h %02h %02h", $time,
                 out_red, out_green, out_blue, out_alpha);
      end else begin
        want = blended_q.pop_front();
        if (out_red !== want.red) begin
          errors++;
          $display("%0t out_red expected %02h got %02h", $time, want.red, out_red);
        end
        if (out_green !== want.green) begin
          errors++;
          $display("%0t out_green expected %02h got %02h", $time, want.green, out_green);
        end
        if (out_blue !== want.blue) begin
          errors++;
          $display("%0t out_blue expected %02h got %02h", $time, want.blue, out_blue);
        end
        if (out_alpha !== want.alpha) begin
          errors++;
          $display("%0t out_alpha expected %02h got %02h", $time, want.alpha, out_alpha);
        end
      end
    end
  end

  // receiver stall pattern, with a long hold-off whenever hold_seq moves
  initial begin : rx_stall_gen
    int hold_left;
    int seen_seq;
    int run_left;
    bit run_stall;
    bit stall_now;
    hold_left = 0;
    seen_seq = 0;
    run_left = 0;
    run_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != seen_seq) begin
        seen_seq = hold_seq;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        stall_now = 1'b1;
        hold_left--;
      end else begin
        case (rx_mode)
          RX_RANDOM: stall_now = ($urandom_range(0, 3) == 0);
          RX_BURSTY: begin
            if (run_left == 0) begin
              run_stall = !run_stall;
              run_left = run_stall ? $urandom_range(1, 5) : $urandom_range(1, 10);
            end
            run_left--;
            stall_now = run_stall;
          end
          default: stall_now = 1'b0;
        endcase
      end
      out_stall <= stall_now;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [CHAN_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_SRC_FACTOR:  cur_src_factor = data[FACTOR_W-1:0];
      REG_DST_FACTOR:  cur_dst_factor = data[FACTOR_W-1:0];
      REG_EQUATION:    cur_equation = data[EQ_W-1:0];
      REG_CONST_RED:   cur_const_red = data;
      REG_CONST_GREEN: cur_const_green = data;
      REG_CONST_BLUE:  cur_const_blue = data;
      REG_CONST_ALPHA: cur_const_alpha = data;
      default: ;
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_blend(logic [FACTOR_W-1:0] sf, logic [FACTOR_W-1:0] df,
                           logic [EQ_W-1:0] eq);
    write_reg(REG_SRC_FACTOR, {4'($urandom), sf});
    write_reg(REG_DST_FACTOR, {4'($urandom), df});
    write_reg(REG_EQUATION, {5'($urandom), eq});
  endtask

  task automatic set_const(rgba_t c);
    write_reg(REG_CONST_RED, c.red);
    write_reg(REG_CONST_GREEN, c.green);
    write_reg(REG_CONST_BLUE, c.blue);
    write_reg(REG_CONST_ALPHA, c.alpha);
  endtask

  // holds the beat until it is taken
  task automatic send_pixel(rgba_t s, rgba_t d);
    pix_valid <= 1'b1;
    src_pix <= s;
    dst_pix <= d;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
  endtask

  task automatic send_stream(int count, bit with_gaps);
    int burst_left;
    burst_left = $urandom_range(1, 12);
    for (int i = 0; i < count; i++) begin
      send_pixel(rand_pixel(), rand_pixel());
      burst_left--;
      if (with_gaps && burst_left == 0 && i != count - 1) begin
        pix_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  // no beat in flight once this returns, so setup may change
  task automatic settle();
    pix_valid <= 1'b0;
    while (blended_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_setup();
    rx_mode <= RX_RANDOM;
    send_pixel('0, '0);
    send_pixel('1, '1);
    send_pixel('1, '0);
    send_pixel('0, '1);
    settle();
  endtask

  task automatic test_factor_codes();
    set_const('{red: 8'h00, green: 8'h7F, blue: 8'hFF, alpha: 8'hC3});
    for (int code = 0; code < 16; code++) begin
      set_blend(FACTOR_W'(code), FACTOR_W'(15 - code), EQ_W'(code));
      send_pixel(rand_pixel(), rand_pixel());
      settle();
    end
  endtask

  task automatic test_special_cases();
    // saturation at both ends
    set_blend(FACTOR_ONE, FACTOR_ONE, EQ_ADD);
    send_pixel('1, '{red: 8'h01, green: 8'hFF, blue: 8'h80, alpha: 8'hFF});
    settle();
    set_blend(FACTOR_ONE, FACTOR_ONE, EQ_SUB);
    send_pixel('{red: 8'h01, green: 8'h00, blue: 8'h7F, alpha: 8'h10}, '1);
    settle();
    // a write past the last register must leave the setup alone
    write_reg(REG_UNUSED, 8'hFF);
    send_pixel(rand_pixel(), rand_pixel());
    settle();
    set_blend(FACTOR_ALPHA_SAT, FACTOR_INV_SRC_ALPHA, EQ_MAX);
    send_pixel('{red: 8'h90, green: 8'h20, blue: 8'hFF, alpha: 8'h60},
               '{red: 8'h30, green: 8'hE0, blue: 8'h00, alpha: 8'hB0});
    settle();
  endtask

  task automatic test_random_blend();
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          set_blend(FACTOR_INV_CONST_ALPHA, FACTOR_INV_CONST_ALPHA, EQ_MAX);
          set_const('1);
        end
        1: begin
          set_blend(FACTOR_ZERO, 4'hF, 3'h7);
          set_const('0);
        end
        default: begin
          set_blend(FACTOR_W'($urandom_range(0, 15)), FACTOR_W'($urandom_range(0, 15)),
                    EQ_W'($urandom_range(0, 7)));
          set_const(rand_pixel());
          if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, rand_channel());
        end
      endcase
      rx_mode <= (ph % 2 == 0) ? RX_RANDOM : RX_BURSTY;
      send_stream(PHASE_BEATS, 1'b1);
      settle();
    end
  endtask

  task automatic test_back_pressure();
    set_blend(FACTOR_SRC_ALPHA, FACTOR_INV_SRC_ALPHA, EQ_ADD);
    rx_mode <= RX_READY;
    hold_seq <= hold_seq + 1;
    send_stream(PHASE_BEATS, 1'b0);
    settle();
  endtask

  task automatic test_full_rate();
    set_blend(FACTOR_DST_COL, FACTOR_SRC_COL, EQ_REV_SUB);
    rx_mode <= RX_READY;
    send_stream(PHASE_BEATS, 1'b0);
    settle();
  endtask

  initial begin
    int waited;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_setup();
    test_factor_codes();
    test_special_cases();
    test_random_blend();
    test_back_pressure();
    test_full_rate();
    pix_valid <= 1'b0;
    waited = 0;
    while (blended_q.size() != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (blended_q.size() != 0) begin
      errors++;
      $display("%0t %0d expected beats never arrived", $time, blended_q.size());
    end
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* rgba_blend_unit.f */
hw/rtl/rbu_pkg.sv
hw/rtl/rbu_channel.sv
hw/rtl/rgba_blend_unit.sv
bench/tb_rgba_blend_unit.sv
